// ----- src/ilir_pkg.sv -----
// shared codes, defaults and result type for the indexed list block
package ilir_pkg;

  // default sizes
  localparam int DEF_CAPACITY      = 16;
  localparam int DEF_ELEMENT_WIDTH = 32;

  // port field widths
  localparam int MODE_W  = 2;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INSERT = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE      = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL       = 2'd3;

  // one finished result
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } res_t;

endpackage

// ----- src/ilir_mem.sv -----
// element store: one write port, one registered read port
module ilir_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ilir_seq.sv -----
// sequencer: decodes an item and walks the store one entry move at a time
module ilir_seq #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32,
  parameter int AW            = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  // item input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ilir_pkg::MODE_W-1:0]  mode,
  input  logic [ilir_pkg::POS_W-1:0]   position,
  input  logic [ilir_pkg::VALUE_W-1:0] value,
  // finished result
  output logic                       res_valid,
  input  logic                       res_ready,
  output ilir_pkg::res_t             res,
  // store port
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [ELEMENT_WIDTH-1:0]   wdata,
  output logic [AW-1:0]              raddr,
  input  logic [ELEMENT_WIDTH-1:0]   rdata
);
  import ilir_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_FETCH   = 4'd4;
  localparam logic [3:0] S_CAPT    = 4'd5;
  localparam logic [3:0] S_RM_RD   = 4'd6;
  localparam logic [3:0] S_RM_WR   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]               state, state_next;
  logic [LW-1:0]            len, len_next;
  logic [AW-1:0]            idx, idx_next;
  logic [POS_W-1:0]         pos_r, pos_r_next;
  logic [MODE_W-1:0]        mode_r, mode_r_next;
  logic [ELEMENT_WIDTH-1:0] val_r, val_r_next;
  logic [DATA_W-1:0]        data_r, data_r_next;
  logic [STAT_W-1:0]        status_r, status_r_next;

  logic [CW-1:0] pos_in_ext, pos_ext, len_ext, idx_ext;

  assign pos_in_ext = CW'(position);
  assign pos_ext    = CW'(pos_r);
  assign len_ext    = CW'(len);
  assign idx_ext    = CW'(idx);

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.data      = data_r;
  assign res.status    = status_r;
  assign res.count     = COUNT_W'(len);
  assign res.empty_res = (len == '0);

  // next state and store control
  always_comb begin
    state_next    = state;
    len_next      = len;
    idx_next      = idx;
    pos_r_next    = pos_r;
    mode_r_next   = mode_r;
    val_r_next    = val_r;
    data_r_next   = data_r;
    status_r_next = status_r;
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    raddr = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          pos_r_next    = position;
          mode_r_next   = mode;
          val_r_next    = ELEMENT_WIDTH'(value);
          data_r_next   = '0;
          status_r_next = ST_OK;
          unique case (mode)
            MODE_INSERT: begin
              if (pos_in_ext > len_ext) begin
                status_r_next = ST_BAD_INSERT;
                state_next    = S_DONE;
              end else if (len_ext >= CW'(CAPACITY)) begin
                status_r_next = ST_FULL;
                state_next    = S_DONE;
              end else if (pos_in_ext == len_ext) begin
                state_next = S_INS_PUT;
              end else begin
                idx_next   = AW'(len);
                state_next = S_INS_RD;
              end
            end
            MODE_REMOVE, MODE_READ: begin
              if (pos_in_ext >= len_ext) begin
                status_r_next = ST_RANGE;
                state_next    = S_DONE;
              end else begin
                state_next = S_FETCH;
              end
            end
            default: begin
              len_next   = '0;
              state_next = S_DONE;
            end
          endcase
        end
      end
      // insert: move entry idx-1 up to idx
      S_INS_RD: begin
        raddr      = AW'(idx - AW'(1));
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        we       = 1'b1;
        waddr    = idx;
        wdata    = rdata;
        idx_next = AW'(idx - AW'(1));
        if (idx_ext > pos_ext + CW'(1)) begin
          state_next = S_INS_RD;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        we         = 1'b1;
        waddr      = AW'(pos_r);
        wdata      = val_r;
        len_next   = LW'(len + LW'(1));
        state_next = S_DONE;
      end
      // remove and read: fetch the addressed entry
      S_FETCH: begin
        raddr      = AW'(pos_r);
        state_next = S_CAPT;
      end
      S_CAPT: begin
        data_r_next = DATA_W'(rdata);
        idx_next    = AW'(pos_r);
        if (mode_r == MODE_READ) begin
          state_next = S_DONE;
        end else if (pos_ext + CW'(1) < len_ext) begin
          state_next = S_RM_RD;
        end else begin
          len_next   = LW'(len - LW'(1));
          state_next = S_DONE;
        end
      end
      // remove: move entry idx+1 down to idx
      S_RM_RD: begin
        raddr      = AW'(idx + AW'(1));
        state_next = S_RM_WR;
      end
      S_RM_WR: begin
        we       = 1'b1;
        waddr    = idx;
        wdata    = rdata;
        idx_next = AW'(idx + AW'(1));
        if (idx_ext + CW'(2) < len_ext) begin
          state_next = S_RM_RD;
        end else begin
          len_next   = LW'(len - LW'(1));
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pos_r    <= pos_r_next;
    mode_r   <= mode_r_next;
    val_r    <= val_r_next;
    data_r   <= data_r_next;
    status_r <= status_r_next;
  end

endmodule

// ----- src/indexed_list_insert_remove_core.sv -----
// top level of the bounded indexed list with insert, remove, read and clear
//
// Input channel (in_valid / in_stall) carries one operation per item: mode,
// position and value. Output channel (out_valid / out_stall) returns one item
// per operation: data, status, count and empty_res.
// Each item is handled by a sequencer that moves one list entry at a time,
// read then write, through a single-port-write, registered-read store.
// Insert shifts entries from position up, then writes the value; remove and
// read fetch the entry, remove then shifts later entries down; clear and
// errors go straight to the result. A new item is accepted only in S_IDLE,
// entered as the previous result moves into the output register.
// in_stall is high while an item is in work.
// When the receiver stalls, the result holds in the output register and the
// sequencer takes the next item; its result waits in the sequencer until the
// output register frees, and in_stall stays high meanwhile.
// Reset empties the list (count 0) and drops any pending result; store
// contents are not cleared, an entry is only read after it was written.
module indexed_list_insert_remove_core #(
  parameter int CAPACITY      = ilir_pkg::DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = ilir_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ilir_pkg::MODE_W-1:0]  mode,
  input  logic [ilir_pkg::POS_W-1:0]   position,
  input  logic [ilir_pkg::VALUE_W-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ilir_pkg::DATA_W-1:0]  data,
  output logic [ilir_pkg::STAT_W-1:0]  status,
  output logic [ilir_pkg::COUNT_W-1:0] count,
  output logic                         empty_res
);
  import ilir_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                     res_valid;
  logic                     res_ready;
  res_t                     res;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [AW-1:0]            raddr;
  logic [ELEMENT_WIDTH-1:0] rdata;
  res_t                     out_r;

  ilir_seq #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .AW            (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  ilir_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register frees when empty or being taken
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign data      = out_r.data;
  assign status    = out_r.status;
  assign count     = out_r.count;
  assign empty_res = out_r.empty_res;

endmodule

// ----- src/ilir_chk.sv -----
// port-level checks for the indexed list, bound to the top level
module ilir_chk #(
  parameter int CAPACITY = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ilir_pkg::DATA_W-1:0]  data,
  input logic [ilir_pkg::STAT_W-1:0]  status,
  input logic [ilir_pkg::COUNT_W-1:0] count,
  input logic                         empty_res
);
  import ilir_pkg::*;

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // nothing is offered and input is open right after reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

  // errors and full return zero data
  a_err_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data == '0)
    else $error("nonzero data on error status");

  // full is only reported at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == COUNT_W'(CAPACITY))
    else $error("full status below capacity");

  // empty flag agrees with count when count fits the port
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY >= 32) || (empty_res == (count == '0)))
    else $error("empty flag disagrees with count");

endmodule

bind indexed_list_insert_remove_core ilir_chk #(
  .CAPACITY (CAPACITY)
) u_ilir_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data      (data),
  .status    (status),
  .count     (count),
  .empty_res (empty_res)
);

// ----- bench/tb_indexed_list_insert_remove_core.sv -----
// testbench for the indexed list core: list shadow with result checking under random idling
`timescale 1ns / 100ps

module tb_indexed_list_insert_remove_core;
  import ilir_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 475;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 48;
  localparam int PRINT_LIMIT  = 40;

  // shadow of the list contents plus the queue of results still owed by the core
  class list_scoreboard;
    logic [DATA_W-1:0] slots [CAP];
    int unsigned       fill;
    res_t              pending_results [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       peak_fill;
    int unsigned       mode_hits [4];
    int unsigned       status_hits [4];

    function new();
      fill       = 0;
      mismatches = 0;
      checked    = 0;
      peak_fill  = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    // carry out one list operation on the shadow and return what the core should answer
    function res_t apply_list_op(logic [MODE_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [VALUE_W-1:0] val);
      res_t        r;
      int unsigned i;
      r = '0;
      r.status = ST_OK;
      case (op)
        MODE_INSERT: begin
          if (pos > fill) begin
            r.status = ST_BAD_INSERT;
          end else if (fill >= CAP) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = val;
            fill++;
          end
        end
        MODE_REMOVE: begin
          if (pos >= fill) begin
            r.status = ST_RANGE;
          end else begin
            r.data = slots[pos];
            for (i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
          end
        end
        MODE_READ: begin
          if (pos >= fill) r.status = ST_RANGE;
          else r.data = slots[pos];
        end
        default: begin
          fill = 0;
        end
      endcase
      r.count     = fill[COUNT_W-1:0];
      r.empty_res = (fill == 0);
      return r;
    endfunction

    // accepted input item: predict and queue its result
    function void note_item(logic [MODE_W-1:0] op, logic [POS_W-1:0] pos,
                            logic [VALUE_W-1:0] val);
      res_t r;
      r = apply_list_op(op, pos, val);
      pending_results.push_back(r);
      mode_hits[op]++;
      status_hits[r.status]++;
      if (fill > peak_fill) peak_fill = fill;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("tb: mismatch %0d at %0t ns: %s", mismatches, $time, what);
    endtask

    // accepted result item: compare against the oldest prediction
    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: data %h status %0d count %0d",
                                  got.data, got.status, got.count));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.data !== want.data)
        report_mismatch($sformatf("result %0d data %h, expected %h",
                                  checked, got.data, want.data));
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  checked, got.status, want.status));
      if (got.count !== want.count)
        report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                  checked, got.count, want.count));
      if (got.empty_res !== want.empty_res)
        report_mismatch($sformatf("result %0d empty_res %b, expected %b",
                                  checked, got.empty_res, want.empty_res));
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [MODE_W-1:0]    mode      = MODE_CLEAR;
  logic [POS_W-1:0]     position  = '0;
  logic [VALUE_W-1:0]   value     = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [DATA_W-1:0]    data;
  logic [STAT_W-1:0]    status;
  logic [COUNT_W-1:0]   count;
  logic                 empty_res;

  list_scoreboard board = new();

  int unsigned idle_cycles = 0;
  int unsigned stall_hold  = 0;
  int unsigned burst_left  = 0;
  int unsigned target_fill = 0;

  always #10 clk = ~clk;

  indexed_list_insert_remove_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .status    (status),
    .count     (count),
    .empty_res (empty_res)
  );

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(res_t'({data, status, count, empty_res}));
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: stalled for %0d cycles with %0d results pending",
               idle_cycles, board.pending_results.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls: mostly short runs, some long, some long quiet stretches
  always @(posedge clk) begin
    int unsigned r;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 6);
      end else if (r < 82) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else if (r < 94) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(20, 60);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  // sender gap before the next item, with bursts of back-to-back items
  function int unsigned next_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function logic [VALUE_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // present one item and hold it until the core takes it
  task drive_item(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
                  input logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(op, pos, val);
  endtask

  // mostly well-formed operations steered toward a moving target length
  task pick_random_item(output logic [MODE_W-1:0] op, output logic [POS_W-1:0] pos,
                        output logic [VALUE_W-1:0] val);
    int unsigned r;
    int unsigned n;
    n   = board.fill;
    r   = $urandom_range(0, 99);
    val = random_value();
    pos = POS_W'($urandom);
    if (r < 3) begin
      op = MODE_CLEAR;
    end else if (r < 12) begin
      // position past the valid range
      case ($urandom_range(0, 2))
        0: begin
          op  = MODE_INSERT;
          pos = POS_W'($urandom_range(n + 1, 31));
        end
        1: begin
          op  = MODE_REMOVE;
          pos = POS_W'($urandom_range(n, 31));
        end
        default: begin
          op  = MODE_READ;
          pos = POS_W'($urandom_range(n, 31));
        end
      endcase
    end else if (n != 0 && r < 35) begin
      op  = MODE_READ;
      pos = POS_W'($urandom_range(0, n - 1));
    end else if (n == 0 || n < target_fill || (n == target_fill && r[0])) begin
      op  = MODE_INSERT;
      pos = POS_W'($urandom_range(0, n));
    end else begin
      op  = MODE_REMOVE;
      pos = POS_W'($urandom_range(0, n - 1));
    end
  endtask

  initial begin
    logic [MODE_W-1:0]  op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    int unsigned        k;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list corner cases
    drive_item(MODE_CLEAR, 0, 32'h0);
    drive_item(MODE_READ, 0, 32'h0);
    drive_item(MODE_REMOVE, 0, 32'h0);
    drive_item(MODE_INSERT, 1, 32'h1234_5678);
    // insert at front, append, middle
    drive_item(MODE_INSERT, 0, 32'h0000_0000);
    drive_item(MODE_INSERT, 1, 32'hFFFF_FFFF);
    drive_item(MODE_INSERT, 1, 32'hA5A5_5A5A);
    drive_item(MODE_INSERT, 0, 32'h0000_0001);
    drive_item(MODE_READ, 3, 32'h0);
    drive_item(MODE_READ, 4, 32'h0);
    // fill the list to capacity
    while (board.fill < CAP)
      drive_item(MODE_INSERT, POS_W'($urandom_range(0, board.fill)), VALUE_W'($urandom));
    // full list: valid position gives full, bad position wins over full
    drive_item(MODE_INSERT, 16, 32'hDEAD_BEEF);
    drive_item(MODE_INSERT, 31, 32'hDEAD_BEEF);
    drive_item(MODE_READ, 16, 32'h0);
    drive_item(MODE_REMOVE, 15, 32'h0);
    drive_item(MODE_REMOVE, 0, 32'h0);
    drive_item(MODE_READ, 31, 32'h0);
    drive_item(MODE_CLEAR, 5, 32'h0);

    // random operations
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) target_fill = $urandom_range(0, CAP);
      pick_random_item(op, pos, val);
      drive_item(op, pos, val);
    end
    in_valid <= 1'b0;

    // drain, then allow late extra results to show up
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d operations (insert %0d, remove %0d, read %0d, clear %0d), peak length %0d",
             board.checked, board.mode_hits[MODE_INSERT], board.mode_hits[MODE_REMOVE],
             board.mode_hits[MODE_READ], board.mode_hits[MODE_CLEAR], board.peak_fill);
    $display("tb: statuses ok %0d, bad insert %0d, out of range %0d, full %0d; %0d mismatches",
             board.status_hits[ST_OK], board.status_hits[ST_BAD_INSERT],
             board.status_hits[ST_RANGE], board.status_hits[ST_FULL], board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
